// ===== rtl/bfa_pkg.sv =====
// Package: binary32 field widths, constants and a leading-zero-count normalize helper.
package bfa_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned MantW = 28;
  localparam logic [WordW-1:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  typedef logic [WordW-1:0] word_t;

  // leading zero count over 28 bits (at most 28)
  function automatic logic [4:0] lzc28(input logic [MantW-1:0] v);
    logic [4:0] n;
    logic found;
    n = 5'd0;
    found = 1'b0;
    for (int i = MantW - 1; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction
endpackage

// ===== rtl/bfa_core.sv =====
// Combinational binary32 add with round to nearest even.
module bfa_core (
  input  bfa_pkg::word_t a,
  input  bfa_pkg::word_t b,
  output bfa_pkg::word_t sum
);
  import bfa_pkg::*;

  logic sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
  logic [ExpW-1:0] ea, eb, ex, ey;
  logic [MantW-1:0] ma, mb, mx, my, my_sh, m1, m2, m3;
  logic [ExpW-1:0] d;
  logic [MantW-1:0] lost_mask;
  logic sx, sy;
  logic [MantW:0] msum;
  logic [9:0] e1, e2, e3, efin;
  logic [4:0] lz, sh;
  logic lsb, g, rest_nz;
  logic [24:0] mr;
  word_t fin;

  always_comb begin
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    nan_a = (ea == ExpMax) && (a[22:0] != '0);
    nan_b = (eb == ExpMax) && (b[22:0] != '0);
    inf_a = (ea == ExpMax) && (a[22:0] == '0);
    inf_b = (eb == ExpMax) && (b[22:0] == '0);
    zero_a = (ea == '0) && (a[22:0] == '0);
    zero_b = (eb == '0) && (b[22:0] == '0);
    ma = {1'b0, (ea != '0), a[22:0], 3'b000};
    mb = {1'b0, (eb != '0), b[22:0], 3'b000};
    if (ea == '0) ea = 8'd1;
    if (eb == '0) eb = 8'd1;
    swap = (eb > ea) || ((eb == ea) && (mb > ma));
    mx = swap ? mb : ma; my = swap ? ma : mb;
    ex = swap ? eb : ea; ey = swap ? ea : eb;
    sx = swap ? sb : sa; sy = swap ? sa : sb;
    d = ex - ey;
    lost_mask = ~({MantW{1'b1}} << d[4:0]);
    if (d >= 8'd28) begin
      my_sh = {{(MantW-1){1'b0}}, (my != '0)};
    end else begin
      my_sh = (my >> d[4:0]) | {{(MantW-1){1'b0}}, ((my & lost_mask) != '0)};
    end
    if (sx == sy) msum = {1'b0, mx} + {1'b0, my_sh};
    else msum = {1'b0, mx} - {1'b0, my_sh};
    m1 = msum[MantW-1:0];
    e1 = {2'b00, ex};
    if (m1[27]) begin
      m1 = (m1 >> 1) | {{(MantW-1){1'b0}}, m1[0]};
      e1 = e1 + 10'd1;
    end
    lz = lzc28(m1) - 5'd1;
    if ({5'd0, lz} > e1 - 10'd1) sh = 5'(e1 - 10'd1);
    else sh = lz;
    if (m1[26]) sh = 5'd0;
    m2 = m1 << sh;
    e2 = e1 - {5'd0, sh};
    lsb = m2[3]; g = m2[2]; rest_nz = (m2[1:0] != 2'b00);
    mr = {1'b0, m2[26:3]} + {24'd0, (g && (rest_nz || lsb))};
    m3 = {3'b000, mr};
    e3 = e2;
    if (mr[24]) begin
      m3 = {3'b000, mr} >> 1;
      e3 = e2 + 10'd1;
    end
    efin = m3[23] ? e3 : 10'd0;
    if (efin >= 10'd255) fin = {sx, ExpMax, 23'd0};
    else fin = {sx, efin[7:0], m3[22:0]};
    if ((sx != sy) && (m1 == '0)) fin = '0;

    if (nan_a || nan_b) sum = DefaultNan;
    else if (inf_a && inf_b) sum = (sa == sb) ? a : DefaultNan;
    else if (inf_a) sum = a;
    else if (inf_b) sum = b;
    else if (zero_a && zero_b) sum = {sa & sb, 31'd0};
    else if (zero_a) sum = b;
    else if (zero_b) sum = a;
    else sum = fin;
  end
endmodule

// ===== rtl/binary32_float_adder.sv =====
// Top level: registered binary32 adder with valid/stall channels.
// Usage:
//   Input channel: in_valid with operand_a/operand_b; in_stall from this block.
//   Output channel: out_valid with sum_bits; out_stall from the receiver.
//   An item is taken when valid is high and stall is low.
//   Path: an accepted item goes to the operand register, then the result register drives sum_bits.
//   Throughput: one item per cycle while out_stall is low; the operand register feeds a single
//   combinational add/normalize/round path into the result register.
//   When the receiver stalls, the result register holds and the operand
//   register keeps its item; in_stall rises only while both are full and
//   the output is stalled.
//   Reset clears both valid flags; no item is pending afterward.
//   Results come out in input order, round to nearest even, default NaN
//   0x7FC00000.
module binary32_float_adder (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bfa_pkg::word_t operand_a,
  input  bfa_pkg::word_t operand_b,
  output logic           out_valid,
  input  logic           out_stall,
  output bfa_pkg::word_t sum_bits
);
  import bfa_pkg::*;

  logic  op_valid;
  word_t op_a, op_b, sum_next;
  logic  adv;

  bfa_core u_core (.a(op_a), .b(op_b), .sum(sum_next));

  assign adv = !out_valid || !out_stall;
  assign in_stall = op_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) out_valid <= op_valid;
      if (!in_stall) op_valid <= in_valid;
    end
    if (adv && op_valid) sum_bits <= sum_next;
    if (!in_stall && in_valid) begin
      op_a <= operand_a;
      op_b <= operand_b;
    end
  end
endmodule

// ===== rtl/bfa_checker.sv =====
// Port-level checker for the binary32 adder, bound to the top level.
module bfa_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input bfa_pkg::word_t operand_a,
  input bfa_pkg::word_t operand_b,
  input logic           out_valid,
  input logic           out_stall,
  input bfa_pkg::word_t sum_bits
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sum_bits))
    else $error("stalled result changed");
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
    else $error("item lost");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind binary32_float_adder bfa_checker u_bfa_checker (.*);

// ===== test/tb.sv =====
// Testbench for binary32_float_adder: directed and random pairs checked against a local model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int unsigned NumRandom = 1700;
  localparam longint unsigned CycleLimit = 400000;

  // expected sums, in order
  class sum_board;
    word_t pending[$];
    int unsigned n_err;
    int unsigned n_ok;

    function word_t add_f32(word_t a, word_t b);
      logic sa, sb, sgn;
      logic [7:0] ea, eb, te;
      logic [22:0] fa, fb;
      logic [63:0] ma, mb, m, tm;
      logic [31:0] e, d;
      logic g, lsb, ts;
      logic [1:0] rest;
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      fa = a[22:0]; fb = b[22:0];
      if ((ea == ExpMax && fa != 0) || (eb == ExpMax && fb != 0)) return DefaultNan;
      if (ea == ExpMax && eb == ExpMax) return (sa == sb) ? a : DefaultNan;
      if (ea == ExpMax) return a;
      if (eb == ExpMax) return b;
      if (ea == 0 && fa == 0 && eb == 0 && fb == 0) return {sa & sb, 31'd0};
      if (ea == 0 && fa == 0) return b;
      if (eb == 0 && fb == 0) return a;
      ma = {40'd0, (ea != 0), fa} << 3;
      mb = {40'd0, (eb != 0), fb} << 3;
      if (ea == 0) ea = 8'd1;
      if (eb == 0) eb = 8'd1;
      if (eb > ea || (eb == ea && mb > ma)) begin
        tm = ma; te = ea; ts = sa;
        ma = mb; ea = eb; sa = sb;
        mb = tm; eb = te; sb = ts;
      end
      d = {24'd0, 8'(ea - eb)};
      if (d >= 32) mb = (mb != 0) ? 64'd1 : 64'd0;
      else if (d > 0) mb = (mb >> d) | (((mb & ((64'd1 << d) - 1)) != 0) ? 64'd1 : 64'd0);
      sgn = sa;
      e = {24'd0, ea};
      if (sa == sb) m = ma + mb;
      else begin
        m = ma - mb;
        if (m == 0) return 32'd0;
      end
      if (m[27]) begin
        m = (m >> 1) | {63'd0, m[0]};
        e = e + 1;
      end
      while (!m[26] && e > 1) begin
        m = m << 1;
        e = e - 1;
      end
      lsb = m[3]; g = m[2]; rest = m[1:0];
      m = m >> 3;
      if (g && (rest != 0 || lsb)) m = m + 64'd1;
      if (m[24]) begin
        m = m >> 1;
        e = e + 1;
      end
      if (!m[23]) e = 0;
      if (e >= 255) return {sgn, ExpMax, 23'd0};
      return {sgn, e[7:0], m[22:0]};
    endfunction

    function void note_operands(word_t a, word_t b);
      pending.push_back(add_f32(a, b));
    endfunction

    function void check_sum(word_t got);
      word_t want;
      if (pending.size() == 0) begin
        $error("sum_bits: no item expected, actual %h", got);
        n_err++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $error("sum_bits: expected %h, actual %h", want, got);
        n_err++;
      end else n_ok++;
    endfunction
  endclass

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  word_t operand_a, operand_b, sum_bits;
  sum_board board;
  longint unsigned cycles = 0;
  bit send_done;

  binary32_float_adder u_top (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random float biased toward interesting exponents
  function automatic word_t rand_f32(word_t near);
    word_t v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'd0;
      1: v[30:23] = ExpMax;
      2: v[30:23] = 8'hFE;
      3: v[30:23] = 8'($urandom_range(0, 3));
      4, 5, 6: v[30:23] = 8'(near[30:23] + $urandom_range(0, 4) - 2);
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) v[22:0] = '0;
    return v;
  endfunction

  task automatic send_item(word_t a, word_t b);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_operands(a, b);
  endtask

  // output side: random stalls, checks at the edge
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else begin
      if (out_valid && !out_stall) board.check_sum(sum_bits);
      out_stall <= ($urandom_range(0, 9) < 3) && (($urandom_range(0, 3) != 0) || !send_done);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    word_t dir_a[$];
    word_t dir_b[$];
    word_t x;
    board = new();
    send_done = 0;
    rst = 1'b1; in_valid = 1'b0;
    operand_a = '0; operand_b = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    dir_a = {32'h7FC00001, 32'h3F800000, 32'h7F800000, 32'h7F800000, 32'hFF800000,
             32'h3F800000, 32'h00000000, 32'h80000000, 32'h80000000, 32'h00000000,
             32'h12345678, 32'h3F800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001,
             32'h00800000, 32'h007FFFFF, 32'h3F800000, 32'h3F800001, 32'h4B800000,
             32'hFFFFFFFF, 32'h3F800000};
    dir_b = {32'h3F800000, 32'h7F800001, 32'h7F800000, 32'hFF800000, 32'h3F800000,
             32'h7F800000, 32'h80000000, 32'h80000000, 32'h00000000, 32'hC0000000,
             32'h00000000, 32'hBF800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001,
             32'h80000001, 32'h00000001, 32'h33800000, 32'h33800000, 32'hBF800000,
             32'h00000000, 32'h33800001};
    foreach (dir_a[i]) send_item(dir_a[i], dir_b[i]);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < NumRandom; i++) begin
      x = $urandom();
      if (i == NumRandom / 2) begin
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      x = rand_f32(x);
      send_item(x, ($urandom_range(0, 4) == 0) ? {~x[31], x[30:0]} : rand_f32(x));
    end
    in_valid <= 1'b0;
    send_done = 1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d sums checked: zeros, infinities, NaNs, subnormals, overflow, cancellation",
             board.n_ok + board.n_err);
    $display("tb: plus random pairs near equal exponents with random stalls on both sides");
    if (board.n_err == 0 && board.pending.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
